@@ sv/assert_macros.svh @@
// assertion helpers used by the clock_divider_register_calc rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CDRC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every edge, reset included
`define CDRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/cdrc_pkg.sv @@
// ----------------------------------------------------------------------------
// cdrc_pkg
// Types, constants and the vco frequency table of the divider calculator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdrc_pkg;

   localparam int FREQ_W       = 9;
   localparam int VCO_W        = 12;
   localparam int VMUL_W       = 8;
   localparam int IDX_W        = 6;
   localparam int INT_W        = 12;
   localparam int FRAC_OUT_W   = 24;
   localparam int FRAC_BYTES_W = 30;
   localparam int FB_STEP_MHZ  = 50;
   localparam int MIN_FREQ_MHZ = 10;

   // x / 10 == (x * 205) >> 11 for every x below 1029
   localparam int DIV10_MUL_W  = 8;
   localparam int DIV10_SHIFT  = 11;
   localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 8'd205;

   typedef struct packed {
      logic              valid;
      logic              range_error;
      logic [VMUL_W-1:0] vco_multiplier;
   } sideband_type;

   function automatic logic [VCO_W-1:0] vco_lookup(input logic [IDX_W-1:0] idx);
      logic [VCO_W-1:0] vco;
      case (idx)
         6'd0:    vco = 12'd2500;
         6'd1:    vco = 12'd2500;
         6'd2:    vco = 12'd2550;
         6'd3:    vco = 12'd2500;
         6'd4:    vco = 12'd2500;
         6'd5:    vco = 12'd2550;
         6'd6:    vco = 12'd2800;
         6'd7:    vco = 12'd2500;
         6'd8:    vco = 12'd2700;
         6'd9:    vco = 12'd2500;
         6'd10:   vco = 12'd2750;
         6'd11:   vco = 12'd2550;
         6'd12:   vco = 12'd2600;
         6'd13:   vco = 12'd2800;
         6'd14:   vco = 12'd2550;
         6'd15:   vco = 12'd2600;
         6'd16:   vco = 12'd2550;
         6'd17:   vco = 12'd2700;
         6'd18:   vco = 12'd2850;
         6'd19:   vco = 12'd2500;
         6'd20:   vco = 12'd2500;
         6'd21:   vco = 12'd2750;
         6'd22:   vco = 12'd2500;
         6'd23:   vco = 12'd2700;
         6'd24:   vco = 12'd2500;
         default: vco = '0;
      endcase
      return vco;
   endfunction

   // feedback integer per table slot, the vco over 50 MHz
   function automatic logic [VMUL_W-1:0] vmul_lookup(input logic [IDX_W-1:0] idx);
      logic [VMUL_W-1:0] vmul;
      case (idx)
         6'd0:    vmul = 8'd50;
         6'd1:    vmul = 8'd50;
         6'd2:    vmul = 8'd51;
         6'd3:    vmul = 8'd50;
         6'd4:    vmul = 8'd50;
         6'd5:    vmul = 8'd51;
         6'd6:    vmul = 8'd56;
         6'd7:    vmul = 8'd50;
         6'd8:    vmul = 8'd54;
         6'd9:    vmul = 8'd50;
         6'd10:   vmul = 8'd55;
         6'd11:   vmul = 8'd51;
         6'd12:   vmul = 8'd52;
         6'd13:   vmul = 8'd56;
         6'd14:   vmul = 8'd51;
         6'd15:   vmul = 8'd52;
         6'd16:   vmul = 8'd51;
         6'd17:   vmul = 8'd54;
         6'd18:   vmul = 8'd57;
         6'd19:   vmul = 8'd50;
         6'd20:   vmul = 8'd50;
         6'd21:   vmul = 8'd55;
         6'd22:   vmul = 8'd50;
         6'd23:   vmul = 8'd54;
         6'd24:   vmul = 8'd50;
         default: vmul = '0;
      endcase
      return vmul;
   endfunction

endpackage

@@ sv/clock_divider_register_calc.sv @@
// ----------------------------------------------------------------------------
// clock_divider_register_calc
// Output divider and feedback register bytes of a clock synthesizer from a
// wanted output frequency in MHz.
// ----------------------------------------------------------------------------
// One request carries req_freq_mhz; each request gives exactly one response
// with the integer divider, fractional offset, feedback integer and the packed
// register bytes. Frequencies outside 10..259 MHz return range_error with all
// other fields zero.
// The quotient vco * 2^(FRAC_BITS-1) / freq is formed by a chain of
// restoring division cells, one quotient bit per cell, behind one stage that
// does the range check and table lookup. A request reaches rsp_valid after the
// front register and every cell; throughput is one request per cycle while
// rsp_stall does not hold the chain, each cell working on a different request.
// The whole chain advances together: when a response waits with rsp_stall
// high, the chain holds and req_stall rises until the response is taken.
// Synchronous reset empties the chain; no response is pending after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clock_divider_register_calc import cdrc_pkg::*; #(
   parameter int VCO_TABLE_ENTRIES = 25,
   parameter int FRAC_BITS         = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [FREQ_W-1:0]     req_freq_mhz,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_range_error,
   output logic [INT_W-1:0]      rsp_int_divider,
   output logic [FRAC_OUT_W-1:0] rsp_frac_offset,
   output logic [VMUL_W-1:0]     rsp_vco_multiplier,
   output logic [7:0]            rsp_byte_17,
   output logic [7:0]            rsp_byte_18,
   output logic [7:0]            rsp_byte_22,
   output logic [7:0]            rsp_byte_23,
   output logic [7:0]            rsp_byte_24,
   output logic [7:0]            rsp_byte_25,
   output logic [7:0]            rsp_byte_2d,
   output logic [7:0]            rsp_byte_2e
);

   localparam int QW = VCO_W + FRAC_BITS - 1;

   logic              enable;
   sideband_type      side [QW+1];
   logic [FREQ_W-1:0] div  [QW+1];
   logic [FREQ_W-1:0] rem  [QW+1];
   logic [QW-1:0]     dq   [QW+1];

   logic [INT_W-1:0]        ipart;
   logic [FRAC_BYTES_W-1:0] frac30;

   assign enable    = !side[QW].valid || !rsp_stall;
   assign req_stall = !enable;

   cdrc_front #(
      .VCO_TABLE_ENTRIES (VCO_TABLE_ENTRIES),
      .FRAC_BITS         (FRAC_BITS),
      .QW                (QW)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (req_valid),
      .in_freq  (req_freq_mhz),
      .out_side (side[0]),
      .out_div  (div[0]),
      .out_dq   (dq[0])
   );

   assign rem[0] = '0;

   for (genvar i = 0; i < QW; i++) begin : g_cell
      cdrc_div_cell #(
         .QW (QW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .in_side  (side[i]),
         .in_div   (div[i]),
         .in_rem   (rem[i]),
         .in_dq    (dq[i]),
         .out_side (side[i+1]),
         .out_div  (div[i+1]),
         .out_rem  (rem[i+1]),
         .out_dq   (dq[i+1])
      );
   end

   always_comb begin
      ipart  = INT_W'(dq[QW][QW-1:FRAC_BITS]);
      frac30 = FRAC_BYTES_W'(dq[QW][FRAC_BITS-1:0]);
   end

   assign rsp_valid          = side[QW].valid;
   assign rsp_range_error    = side[QW].range_error;
   assign rsp_int_divider    = ipart;
   assign rsp_frac_offset    = frac30[FRAC_OUT_W-1:0];
   assign rsp_vco_multiplier = side[QW].vco_multiplier;
   assign rsp_byte_17        = {4'h0, side[QW].vco_multiplier[7:4]};
   assign rsp_byte_18        = {side[QW].vco_multiplier[3:0], 4'h0};
   assign rsp_byte_22        = frac30[29:22];
   assign rsp_byte_23        = frac30[21:14];
   assign rsp_byte_24        = frac30[13:6];
   assign rsp_byte_25        = {frac30[5:0], 2'b00};
   assign rsp_byte_2d        = ipart[11:4];
   assign rsp_byte_2e        = {ipart[3:0], 4'h0};

   `CDRC_ASSERT(a_error_zero, clock, reset, (rsp_valid && rsp_range_error) |-> (rsp_int_divider == '0 && rsp_frac_offset == '0 && rsp_vco_multiplier == '0), "range error response with nonzero fields")
   `CDRC_ASSERT(a_rem_below_div, clock, reset, rsp_valid |-> (rem[QW] < div[QW]), "division remainder not below divisor")
   `CDRC_ASSERT(a_hold_on_stall, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(dq[QW]) && $stable(rem[QW])), "chain moved while response stalled")
   `CDRC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "response pending right after reset")

endmodule

@@ sv/cdrc_front.sv @@
// ----------------------------------------------------------------------------
// cdrc_front
// Range check, vco table lookup and divider operand setup, one register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdrc_front import cdrc_pkg::*; #(
   parameter int VCO_TABLE_ENTRIES = 25,
   parameter int FRAC_BITS         = 24,
   parameter int QW                = VCO_W + FRAC_BITS - 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic [FREQ_W-1:0] in_freq,
   output sideband_type      out_side,
   output logic [FREQ_W-1:0] out_div,
   output logic [QW-1:0]     out_dq
);

   localparam int PROD_W = FREQ_W + DIV10_MUL_W;

   logic [PROD_W-1:0] prod;
   logic [IDX_W-1:0]  tens;
   logic [IDX_W-1:0]  idx;
   logic              too_low;
   logic              error;
   logic [VCO_W-1:0]  vco;

   sideband_type      side_ff, side_in;
   logic [FREQ_W-1:0] div_ff, div_in;
   logic [QW-1:0]     dq_ff, dq_in;

   always_comb begin
      prod    = PROD_W'(in_freq) * PROD_W'(DIV10_MUL);
      tens    = prod[DIV10_SHIFT +: IDX_W];
      idx     = tens - IDX_W'(1);
      too_low = in_freq < FREQ_W'(MIN_FREQ_MHZ);
      error   = too_low || ({1'b0, idx} >= (IDX_W + 1)'(VCO_TABLE_ENTRIES));
      vco     = vco_lookup(idx);

      side_in.valid          = in_valid;
      side_in.range_error    = error;
      side_in.vco_multiplier = error ? '0 : vmul_lookup(idx);
      // error requests divide zero by one so the chain yields zero
      div_in = error ? FREQ_W'(1) : in_freq;
      dq_in  = error ? '0 : (QW'(vco) << (FRAC_BITS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (enable) begin
         side_ff <= side_in;
         div_ff  <= div_in;
         dq_ff   <= dq_in;
      end
   end

   assign out_side = side_ff;
   assign out_div  = div_ff;
   assign out_dq   = dq_ff;

endmodule

@@ sv/cdrc_div_cell.sv @@
// ----------------------------------------------------------------------------
// cdrc_div_cell
// One restoring division step: shifts in a dividend bit, produces a quotient bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdrc_div_cell import cdrc_pkg::*; #(
   parameter int QW = 35
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  sideband_type      in_side,
   input  logic [FREQ_W-1:0] in_div,
   input  logic [FREQ_W-1:0] in_rem,
   input  logic [QW-1:0]     in_dq,
   output sideband_type      out_side,
   output logic [FREQ_W-1:0] out_div,
   output logic [FREQ_W-1:0] out_rem,
   output logic [QW-1:0]     out_dq
);

   logic [FREQ_W:0]   trial;
   logic [FREQ_W:0]   diff;
   logic              take;

   sideband_type      side_ff;
   logic [FREQ_W-1:0] div_ff;
   logic [FREQ_W-1:0] rem_ff, rem_in;
   logic [QW-1:0]     dq_ff, dq_in;

   always_comb begin
      trial  = {in_rem, in_dq[QW-1]};
      diff   = trial - {1'b0, in_div};
      take   = trial >= {1'b0, in_div};
      // remainder stays below the divisor, so it fits back in FREQ_W bits
      rem_in = take ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
      dq_in  = {in_dq[QW-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (enable) begin
         side_ff <= in_side;
         div_ff  <= in_div;
         rem_ff  <= rem_in;
         dq_ff   <= dq_in;
      end
   end

   assign out_side = side_ff;
   assign out_div  = div_ff;
   assign out_rem  = rem_ff;
   assign out_dq   = dq_ff;

endmodule
